@@ rtl/core/altb_pkg.sv @@
// Shared types and constants of the adaptive light-to-brightness mapper.
`default_nettype none

package altb_pkg;

   localparam int LIGHT_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int BRIGHT_BITS = 15;
   localparam int SCALE_Q8 = 25600;
   localparam int DIV_STEPS = BRIGHT_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   localparam logic [FIELD_BITS-1:0] LOW_START_RESET = 16'h0000;
   localparam logic [FIELD_BITS-1:0] HIGH_START_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_SAMPLE    = 2'd0,
      CMD_MARK_HIGH = 2'd1,
      CMD_MARK_LOW  = 2'd2,
      CMD_NOP       = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_LOW_START  = 1'b0,
      REG_HIGH_START = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load_start;
      logic take;
      logic mult;
      logic div_step;
      logic emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic go_div;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/altb_ctrl.sv @@
// Sequencer that steps the datapath through window load, clamp, multiply and divide.
`default_nettype none

module altb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire altb_pkg::dp_status_type status,
   output altb_pkg::dp_ctrl_type        ctrl
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [altb_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                               valid_ff, valid_in;
   logic                               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_tready;
      ctrl     = '0;
      case (state_ff)
         ST_INIT: begin
            ctrl.load_start = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.take = 1'b1;
               state_in  = status.go_div ? ST_MULT : ST_FINISH;
            end
         end
         ST_MULT: begin
            ctrl.mult = 1'b1;
            step_in   = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == altb_pkg::STEP_BITS'(altb_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.emit = 1'b1;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/altb_dp.sv @@
// Datapath: light window, clamp, scale multiply, restoring divider and result register.
`default_nettype none

module altb_dp #(
   parameter int LIGHT_BITS = altb_pkg::LIGHT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_index,
   input  wire logic [altb_pkg::FIELD_BITS-1:0]     csr_data,
   input  wire logic [1:0]                          req_command,
   input  wire logic [altb_pkg::FIELD_BITS-1:0]     req_level,
   input  wire altb_pkg::dp_ctrl_type               ctrl,
   output altb_pkg::dp_status_type                  status,
   output logic [altb_pkg::BRIGHT_BITS-1:0]         rsp_bright,
   output logic                                     rsp_empty,
   output logic [altb_pkg::FIELD_BITS-1:0]          rsp_low,
   output logic [altb_pkg::FIELD_BITS-1:0]          rsp_high
);

   localparam int FB = altb_pkg::FIELD_BITS;
   localparam int QB = altb_pkg::BRIGHT_BITS;
   localparam int PB = LIGHT_BITS + QB;

   logic [FB-1:0]          low_start_ff, high_start_ff;
   logic [LIGHT_BITS-1:0]  low_ff, low_in, high_ff, high_in;
   logic [LIGHT_BITS-1:0]  diff_ff, diff_in, den_ff, den_in;
   logic [LIGHT_BITS-1:0]  rem_ff, rem_in;
   logic [QB-1:0]          quo_ff, quo_in;
   logic                   empty_ff, empty_in;
   logic [QB-1:0]          bright_ff;
   logic                   out_empty_ff;
   logic [FB-1:0]          out_low_ff, out_high_ff;

   logic [LIGHT_BITS+FB-1:0] level_wide, low_start_wide, high_start_wide;
   logic [LIGHT_BITS+FB-1:0] low_out_wide, high_out_wide;
   logic [LIGHT_BITS-1:0]    level, clamp_hi, clamp, drop_amt, span;
   logic [LIGHT_BITS:0]      sum_add;
   logic [LIGHT_BITS-1:0]    add_a, add_b;
   logic [PB-1:0]            prod;
   logic [LIGHT_BITS:0]      trial;
   logic                     is_sample, is_empty, trial_ok;
   altb_pkg::cmd_type        cmd;

   assign cmd             = altb_pkg::cmd_type'(req_command);
   assign level_wide      = {{LIGHT_BITS{1'b0}}, req_level};
   assign low_start_wide  = {{LIGHT_BITS{1'b0}}, low_start_ff};
   assign high_start_wide = {{LIGHT_BITS{1'b0}}, high_start_ff};
   assign level           = level_wide[LIGHT_BITS-1:0];

   assign is_sample = (cmd == altb_pkg::CMD_SAMPLE);
   assign is_empty  = (high_ff <= low_ff);
   assign status.go_div = is_sample && !is_empty;

   assign clamp_hi = (level > high_ff) ? high_ff : level;
   assign clamp    = (clamp_hi < low_ff) ? low_ff : clamp_hi;

   // Shared adder for the two window moves.
   always_comb begin
      add_a    = high_ff;
      add_b    = level - low_ff;
      drop_amt = low_ff - level;
      if (cmd == altb_pkg::CMD_MARK_HIGH) begin
         add_a = low_ff;
         add_b = level - high_ff;
      end
      sum_add = {1'b0, add_a} + {1'b0, add_b};
      span    = sum_add[LIGHT_BITS] ? {LIGHT_BITS{1'b1}} : sum_add[LIGHT_BITS-1:0];
   end

   assign prod  = PB'(diff_ff) * PB'(altb_pkg::SCALE_Q8);
   assign trial = {rem_ff, quo_ff[QB-1]};
   assign trial_ok = (trial >= {1'b0, den_ff});

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      diff_in  = diff_ff;
      den_in   = den_ff;
      empty_in = empty_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (ctrl.load_start) begin
         low_in  = low_start_wide[LIGHT_BITS-1:0];
         high_in = high_start_wide[LIGHT_BITS-1:0];
      end
      if (ctrl.take) begin
         diff_in  = clamp - low_ff;
         den_in   = high_ff - low_ff;
         empty_in = is_sample && is_empty;
         quo_in   = '0;
         case (cmd)
            altb_pkg::CMD_MARK_HIGH: begin
               low_in  = (level < high_ff) ? '0 : span;
               high_in = level;
            end
            altb_pkg::CMD_MARK_LOW: begin
               if (level >= low_ff) begin
                  high_in = span;
               end else begin
                  high_in = (drop_amt > high_ff) ? '0 : high_ff - drop_amt;
               end
               low_in = level;
            end
            default: begin
            end
         endcase
      end
      if (ctrl.mult) begin
         rem_in = prod[PB-1:QB];
         quo_in = prod[QB-1:0];
      end
      if (ctrl.div_step) begin
         rem_in = trial_ok ? LIGHT_BITS'(trial - {1'b0, den_ff}) : trial[LIGHT_BITS-1:0];
         quo_in = {quo_ff[QB-2:0], trial_ok};
      end
   end

   assign low_out_wide  = {{FB{1'b0}}, low_ff};
   assign high_out_wide = {{FB{1'b0}}, high_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_start_ff  <= altb_pkg::LOW_START_RESET;
         high_start_ff <= altb_pkg::HIGH_START_RESET;
      end else if (csr_valid) begin
         if (csr_index == altb_pkg::REG_LOW_START) begin
            low_start_ff <= csr_data;
         end else begin
            high_start_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      diff_ff  <= diff_in;
      den_ff   <= den_in;
      empty_ff <= empty_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      if (ctrl.emit) begin
         bright_ff    <= quo_ff;
         out_empty_ff <= empty_ff;
         out_low_ff   <= low_out_wide[FB-1:0];
         out_high_ff  <= high_out_wide[FB-1:0];
      end
   end

   assign rsp_bright = bright_ff;
   assign rsp_empty  = out_empty_ff;
   assign rsp_low    = out_low_ff;
   assign rsp_high   = out_high_ff;

endmodule

`default_nettype wire

@@ rtl/core/adaptive_light_to_brightness.sv @@
// Top level of the adaptive light-to-brightness mapper.
//
// Each request word carries a command in req_tuser and a light reading in
// req_tdata. Every request gives exactly one response word with the
// brightness in Q8 percent, the empty-window flag and the window limits
// after the request. A sample on a non-empty window clamps the reading into
// the window and runs a multiply by 25600 followed by a restoring divider
// that yields one quotient bit per cycle. Such a sample passes through the
// multiply state, the divide steps and the finish state before rsp_tvalid
// rises; mark commands, no-operation commands and samples on an empty window
// go from acceptance straight to the finish state. The finish state waits
// while an untaken word sits in the output register. One request is worked on
// at a time. After reset the window is loaded from the start registers in
// the init state, then req_tready rises. The start registers return to their
// defaults at reset; a write takes effect only at the following window load.
// The response sits in an output register; the next request is taken while
// it waits, and the finished result is held until rsp_tready is high.
`default_nettype none

module adaptive_light_to_brightness #(
   parameter int LIGHT_BITS = altb_pkg::LIGHT_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // light_level[15:0]
   input  wire logic [1:0]   req_tuser,  // command[1:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,  // brightness_q8[14:0], low_limit, high_limit, pad
   output logic              rsp_tuser   // window_empty
);

   altb_pkg::dp_ctrl_type    ctrl;
   altb_pkg::dp_status_type  status;
   logic [14:0]              bright;
   logic                     empty;
   logic [15:0]              low_limit, high_limit;

   assign csr_ready = 1'b1;

   altb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   altb_dp #(
      .LIGHT_BITS (LIGHT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_command (req_tuser),
      .req_level   (req_tdata),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_bright  (bright),
      .rsp_empty   (empty),
      .rsp_low     (low_limit),
      .rsp_high    (high_limit)
   );

   assign rsp_tdata = {1'b0, high_limit, low_limit, bright};
   assign rsp_tuser = empty;

endmodule

`default_nettype wire

@@ bench/tb_adaptive_light_to_brightness.sv @@
// Self-checking bench for the adaptive light-to-brightness mapper with scoreboard and random traffic.
module tb_adaptive_light_to_brightness;

   typedef struct {
      logic [14:0] brightness;
      logic        empty;
      logic [15:0] low_limit;
      logic [15:0] high_limit;
   } window_result_type;

   class brightness_scoreboard;
      logic [15:0] window_low = 16'h0000;
      logic [15:0] window_high = 16'hFFFF;
      logic [15:0] low_start = altb_pkg::LOW_START_RESET;
      logic [15:0] high_start = altb_pkg::HIGH_START_RESET;
      window_result_type expected_words[$];
      int unsigned mismatches = 0;

      function int unsigned pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 100) $display("mismatch: %s", what);
      endtask

      // Start registers only matter at a window load, and reset happens once.
      function void note_csr(altb_pkg::reg_index_type index, logic [15:0] value);
         if (index == altb_pkg::REG_LOW_START) low_start = value;
         else high_start = value;
      endfunction

      function logic [15:0] add_saturated(logic [15:0] a, logic [15:0] b);
         logic [16:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[16] ? 16'hFFFF : sum[15:0];
      endfunction

      function void note_request(altb_pkg::cmd_type cmd, logic [15:0] level);
         window_result_type w;
         logic [15:0] clamped;
         logic [15:0] shift;
         longint unsigned scaled;
         w.brightness = '0;
         w.empty = 1'b0;
         case (cmd)
            altb_pkg::CMD_SAMPLE: begin
               clamped = level;
               if (clamped > window_high) clamped = window_high;
               if (clamped < window_low) clamped = window_low;
               if (window_high <= window_low) begin
                  w.empty = 1'b1;
               end else begin
                  scaled = 64'(clamped - window_low) * 64'(altb_pkg::SCALE_Q8);
                  w.brightness = 15'(scaled / 64'(window_high - window_low));
               end
            end
            altb_pkg::CMD_MARK_HIGH: begin
               if (level < window_high) window_low = '0;
               else window_low = add_saturated(window_low, level - window_high);
               window_high = level;
            end
            altb_pkg::CMD_MARK_LOW: begin
               if (level >= window_low) begin
                  window_high = add_saturated(window_high, level - window_low);
               end else begin
                  shift = window_low - level;
                  window_high = (shift > window_high) ? 16'h0000 : window_high - shift;
               end
               window_low = level;
            end
            default: begin
            end
         endcase
         w.low_limit = window_low;
         w.high_limit = window_high;
         expected_words.push_back(w);
      endfunction

      task check_response(logic [47:0] data, logic empty_flag);
         window_result_type w;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("response word %h with nothing expected", data));
         end else begin
            w = expected_words.pop_front();
            if (data[14:0] !== w.brightness)
               report_mismatch($sformatf("brightness %0d, expected %0d",
                                         data[14:0], w.brightness));
            if (empty_flag !== w.empty)
               report_mismatch($sformatf("window_empty %b, expected %b", empty_flag, w.empty));
            if (data[30:15] !== w.low_limit)
               report_mismatch($sformatf("low_limit %0d, expected %0d",
                                         data[30:15], w.low_limit));
            if (data[46:31] !== w.high_limit)
               report_mismatch($sformatf("high_limit %0d, expected %0d",
                                         data[46:31], w.high_limit));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   altb_pkg::reg_index_type csr_index = altb_pkg::REG_LOW_START;
   logic [15:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   altb_pkg::cmd_type req_tuser = altb_pkg::CMD_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;

   brightness_scoreboard sb = new();
   bit idling = 1'b1;
   bit hold_request = 1'b0;

   adaptive_light_to_brightness u_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   task automatic send_request(input altb_pkg::cmd_type cmd, input logic [15:0] level);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= level;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, level);
   endtask

   // The trailing cycle keeps the drop of csr_valid apart from the next write.
   task automatic write_csr(input altb_pkg::reg_index_type index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.note_csr(index, value);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_level();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 16'($urandom_range(sb.window_high, sb.window_low));
      if (roll < 7) return 16'($urandom);
      if (roll == 7) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if (roll == 8) return 16'(sb.window_low + $urandom_range(0, 4) - 2);
      return 16'(sb.window_high + $urandom_range(0, 4) - 2);
   endfunction

   task automatic send_random(input int unsigned count);
      int unsigned roll;
      altb_pkg::cmd_type cmd;
      for (int unsigned i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) cmd = altb_pkg::CMD_SAMPLE;
         else if (roll < 70) cmd = altb_pkg::CMD_MARK_HIGH;
         else if (roll < 90) cmd = altb_pkg::CMD_MARK_LOW;
         else cmd = altb_pkg::CMD_NOP;
         if (idling && i == count / 3) hold_request = 1'b1;
         send_request(cmd, pick_level());
      end
   endtask

   initial begin
      int unsigned hold_cycles;
      int unsigned stall_cycles;
      hold_cycles = 0;
      stall_cycles = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles = 300;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_tready <= 1'b0;
         end else if (idling && $urandom_range(0, 6) == 0) begin
            stall_cycles = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_csr(altb_pkg::REG_LOW_START, 16'hFFFF);
      write_csr(altb_pkg::REG_HIGH_START, 16'h0000);

      // Edges of the default window, then walks through every window move.
      send_request(altb_pkg::CMD_SAMPLE, 16'h0000);
      send_request(altb_pkg::CMD_SAMPLE, 16'hFFFF);
      send_request(altb_pkg::CMD_SAMPLE, 16'h8000);
      send_request(altb_pkg::CMD_NOP, 16'hFFFF);
      send_request(altb_pkg::CMD_NOP, 16'h0000);
      send_request(altb_pkg::CMD_MARK_HIGH, 16'd40000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd50000);
      send_request(altb_pkg::CMD_MARK_LOW, 16'd1000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd500);
      send_request(altb_pkg::CMD_SAMPLE, 16'd20000);
      send_request(altb_pkg::CMD_MARK_LOW, 16'hFFFF);
      send_request(altb_pkg::CMD_SAMPLE, 16'd12345);
      send_request(altb_pkg::CMD_MARK_HIGH, 16'h0000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd7);
      send_request(altb_pkg::CMD_MARK_LOW, 16'd30000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd30000);
      send_request(altb_pkg::CMD_MARK_HIGH, 16'd50000);
      send_request(altb_pkg::CMD_MARK_HIGH, 16'd10000);
      send_request(altb_pkg::CMD_MARK_LOW, 16'd5000);
      send_request(altb_pkg::CMD_MARK_LOW, 16'd2000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd9999);
      send_request(altb_pkg::CMD_MARK_LOW, 16'h0000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd10000);
      send_request(altb_pkg::CMD_SAMPLE, 16'd1);

      wait_drained();
      write_csr(altb_pkg::REG_LOW_START, 16'h0000);
      write_csr(altb_pkg::REG_HIGH_START, 16'hFFFF);
      send_random(400);

      wait_drained();
      write_csr(altb_pkg::REG_HIGH_START, 16'($urandom));
      write_csr(altb_pkg::REG_LOW_START, 16'($urandom));
      send_random(300);

      idling = 1'b0;
      send_random(200);

      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
